>>> src/rcarb_pkg.sv
package rcarb_pkg;

    localparam int RANKS     = 64;
    localparam int RANK_W    = $clog2(RANKS);
    localparam int SPEED_W   = 32;
    localparam int DUR_W     = 31;
    localparam int TIME_W    = 64;
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 72;

    localparam logic [RANK_W-1:0] TOP_RANK   = RANK_W'(RANKS - 1);
    localparam logic [TIME_W-1:0] START_TIME = TIME_W'(2);
    localparam logic [TIME_W-1:0] EXP_FOREVER = TIME_W'(0);
    localparam logic [TIME_W-1:0] EXP_ONESHOT = TIME_W'(1);

    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0]  expiry;
        logic [SPEED_W-1:0] angular;
        logic [SPEED_W-1:0] forward;
    } entry_t;

    typedef struct packed {
        logic              rd_en;
        logic [RANK_W-1:0] rd_addr;
        logic              wr_en;
        logic [RANK_W-1:0] wr_addr;
        entry_t            wr_data;
    } tab_req_t;

    typedef struct packed {
        logic               valid;
        logic [SPEED_W-1:0] forward;
        logic [SPEED_W-1:0] angular;
        logic [RANK_W-1:0]  rank;
        logic               last;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_START = 4'b0010,
        ST_TCHK  = 4'b0100,
        ST_SCAN  = 4'b1000
    } state_t;

endpackage

>>> src/rcarb_table.sv
module rcarb_table (
    input  logic                clk,
    input  rcarb_pkg::tab_req_t req,
    output rcarb_pkg::entry_t   rd_data
);

    rcarb_pkg::entry_t mem [rcarb_pkg::RANKS];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

>>> src/rcarb_ctrl.sv
module rcarb_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                in_kind,
    input  logic [rcarb_pkg::RANK_W-1:0]        in_rank,
    input  logic [rcarb_pkg::SPEED_W-1:0]       in_forward,
    input  logic [rcarb_pkg::SPEED_W-1:0]       in_angular,
    input  logic [rcarb_pkg::DUR_W-1:0]         in_duration,
    input  logic                                slot_free,
    output rcarb_pkg::tab_req_t                 req,
    input  rcarb_pkg::entry_t                   rd_data,
    output rcarb_pkg::result_t                  emit
);

    rcarb_pkg::state_t                 state_reg, state_next;
    logic [rcarb_pkg::RANK_W-1:0]      cur_reg, cur_next;
    logic [rcarb_pkg::RANK_W-1:0]      ev_rank_reg, ev_rank_next;
    logic [rcarb_pkg::TIME_W-1:0]      time_reg, time_next;
    logic [rcarb_pkg::RANKS-1:0]       valid_reg, valid_next;

    logic                              accept;
    logic [rcarb_pkg::TIME_W:0]        exp_sum;
    logic [rcarb_pkg::TIME_W-1:0]      new_exp;
    logic [rcarb_pkg::TIME_W-1:0]      ev_exp;
    logic                              ev_top;

    assign in_ready = (state_reg == rcarb_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;

    assign exp_sum = {1'b0, time_reg} + {{(rcarb_pkg::TIME_W + 1 - rcarb_pkg::DUR_W){1'b0}},
                                         in_duration};
    assign ev_top  = (ev_rank_reg == rcarb_pkg::TOP_RANK);
    assign ev_exp  = ev_top ? rcarb_pkg::EXP_FOREVER : rd_data.expiry;

    always_comb
    begin
        if (in_duration == '0)
        begin
            new_exp = rcarb_pkg::EXP_ONESHOT;
        end
        else if (exp_sum[rcarb_pkg::TIME_W])
        begin
            new_exp = '1;
        end
        else
        begin
            new_exp = exp_sum[rcarb_pkg::TIME_W-1:0];
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        ev_rank_next = ev_rank_reg;
        time_next    = time_reg;
        valid_next   = valid_reg;
        req          = '0;
        req.wr_addr  = in_rank;
        req.wr_data.expiry  = new_exp;
        req.wr_data.angular = in_angular;
        req.wr_data.forward = in_forward;
        emit         = '0;
        emit.forward = ev_top ? '0 : rd_data.forward;
        emit.angular = ev_top ? '0 : rd_data.angular;
        emit.rank    = ev_rank_reg;

        case (state_reg)
            rcarb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_kind == rcarb_pkg::KIND_TICK)
                    begin
                        if (time_reg != '1)
                        begin
                            time_next = time_reg + rcarb_pkg::TIME_W'(1);
                        end
                        if (cur_reg != rcarb_pkg::TOP_RANK)
                        begin
                            req.rd_en   = 1'b1;
                            req.rd_addr = cur_reg;
                            state_next  = rcarb_pkg::ST_TCHK;
                        end
                    end
                    else
                    begin
                        ev_rank_next = cur_reg;
                        if (in_rank < rcarb_pkg::TOP_RANK)
                        begin
                            req.wr_en           = 1'b1;
                            valid_next[in_rank] = 1'b1;
                            if (in_rank <= cur_reg)
                            begin
                                cur_next     = in_rank;
                                ev_rank_next = in_rank;
                            end
                        end
                        state_next = rcarb_pkg::ST_START;
                    end
                end
            end

            rcarb_pkg::ST_START:
            begin
                req.rd_en   = 1'b1;
                req.rd_addr = ev_rank_reg;
                state_next  = rcarb_pkg::ST_SCAN;
            end

            rcarb_pkg::ST_TCHK:
            begin
                if ((rd_data.expiry >= rcarb_pkg::TIME_W'(2)) && (rd_data.expiry <= time_reg))
                begin
                    valid_next[cur_reg] = 1'b0;
                    req.rd_en    = 1'b1;
                    req.rd_addr  = cur_reg + rcarb_pkg::RANK_W'(1);
                    ev_rank_next = cur_reg + rcarb_pkg::RANK_W'(1);
                    state_next   = rcarb_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = rcarb_pkg::ST_IDLE;
                end
            end

            rcarb_pkg::ST_SCAN:
            begin
                if (!valid_reg[ev_rank_reg])
                begin
                    req.rd_en    = 1'b1;
                    req.rd_addr  = ev_rank_reg + rcarb_pkg::RANK_W'(1);
                    ev_rank_next = ev_rank_reg + rcarb_pkg::RANK_W'(1);
                end
                else if (ev_top || (ev_exp == rcarb_pkg::EXP_FOREVER) || (ev_exp > time_reg))
                begin
                    if (slot_free)
                    begin
                        emit.valid = 1'b1;
                        emit.last  = 1'b1;
                        cur_next   = ev_rank_reg;
                        state_next = rcarb_pkg::ST_IDLE;
                    end
                end
                else if (ev_exp == rcarb_pkg::EXP_ONESHOT)
                begin
                    // one-shot passed on the way up: sent once, then dropped
                    if (slot_free)
                    begin
                        emit.valid   = 1'b1;
                        valid_next[ev_rank_reg] = 1'b0;
                        req.rd_en    = 1'b1;
                        req.rd_addr  = ev_rank_reg + rcarb_pkg::RANK_W'(1);
                        ev_rank_next = ev_rank_reg + rcarb_pkg::RANK_W'(1);
                    end
                end
                else
                begin
                    valid_next[ev_rank_reg] = 1'b0;
                    req.rd_en    = 1'b1;
                    req.rd_addr  = ev_rank_reg + rcarb_pkg::RANK_W'(1);
                    ev_rank_next = ev_rank_reg + rcarb_pkg::RANK_W'(1);
                end
            end

            default:
            begin
                state_next = rcarb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rcarb_pkg::ST_IDLE;
            cur_reg     <= rcarb_pkg::TOP_RANK;
            ev_rank_reg <= rcarb_pkg::TOP_RANK;
            time_reg    <= rcarb_pkg::START_TIME;
            valid_reg   <= {1'b1, {(rcarb_pkg::RANKS - 1){1'b0}}};
        end
        else
        begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            ev_rank_reg <= ev_rank_next;
            time_reg    <= time_next;
            valid_reg   <= valid_next;
        end
    end

endmodule

>>> src/rcarb_outreg.sv
module rcarb_outreg (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  rcarb_pkg::result_t                    emit,
    output logic                                  slot_free,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [rcarb_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                  m_tlast
);

    logic                            valid_reg, valid_next;
    logic [rcarb_pkg::SPEED_W-1:0]   fwd_reg, ang_reg;
    logic [rcarb_pkg::RANK_W-1:0]    rank_reg;
    logic                            last_reg;

    assign slot_free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (emit.valid)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            fwd_reg  <= emit.forward;
            ang_reg  <= emit.angular;
            rank_reg <= emit.rank;
            last_reg <= emit.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {{(rcarb_pkg::OUT_DATA_W - 2 * rcarb_pkg::SPEED_W - rcarb_pkg::RANK_W){1'b0}},
                       rank_reg, ang_reg, fwd_reg};

endmodule

>>> src/ranked_command_arbiter_with_expiry.sv
// Ranked velocity command arbiter with expiry.
// Slave channel (s_*): one transaction per tick (s_tuser = 0) or command
// insert (s_tuser = 1). Master channel (m_*): speed results, m_tlast on the
// final result caused by a transaction.
// A tick ends at once while the stop rank is current, ends after reading the
// current entry when it is still live, and otherwise scans upward past it.
// An insert scans upward from the winning rank; the pace is set by the single
// read port of the command table, one rank per cycle unless a result waits
// for the receiver.
// The first result of an insert is read in ST_START, checked in ST_SCAN and then
// registered, unless the previous result is still waiting in the output register.
// s_tready is high only while no transaction is in progress.
// Results pass through an output register; a stalled receiver halts the
// scan at the next result to be sent, and nothing is lost.
// Reset clears the valid bits (only the top rank, a permanent stop, stays
// valid), selects the top rank and sets the time counter to two; the table
// contents need no clearing.
module ranked_command_arbiter_with_expiry (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // rank[5:0], forward_speed[37:6], angular_speed[69:38], duration[100:70]
    input  logic [rcarb_pkg::IN_DATA_W-1:0]      s_tdata,
    // kind
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // drive_forward[31:0], drive_angular[63:32], active_rank[69:64]
    output logic [rcarb_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                 m_tlast
);

    rcarb_pkg::tab_req_t req;
    rcarb_pkg::entry_t   rd_data;
    rcarb_pkg::result_t  emit;
    logic                slot_free;

    rcarb_table u_table (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    rcarb_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_kind     (s_tuser),
        .in_rank     (s_tdata[5:0]),
        .in_forward  (s_tdata[37:6]),
        .in_angular  (s_tdata[69:38]),
        .in_duration (s_tdata[100:70]),
        .slot_free   (slot_free),
        .req         (req),
        .rd_data     (rd_data),
        .emit        (emit)
    );

    rcarb_outreg u_outreg (
        .clk       (clk),
        .rst_n     (rst_n),
        .emit      (emit),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

>>> src/rcarb_checker.sv
module rcarb_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_tvalid,
    input logic                                 s_tready,
    input logic                                 s_tuser,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [rcarb_pkg::OUT_DATA_W-1:0]     m_tdata,
    input logic                                 m_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_insert_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == rcarb_pkg::KIND_INSERT) |=> !s_tready)
        else $error("insert did not occupy the block");

    a_oneshot_rank: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> (m_tdata[69:64] != rcarb_pkg::TOP_RANK))
        else $error("non-final result from stop rank");

    a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[69:64] == rcarb_pkg::TOP_RANK) |-> m_tlast && (m_tdata[63:0] == '0))
        else $error("stop rank sent non-zero speeds");

endmodule

bind ranked_command_arbiter_with_expiry rcarb_checker u_rcarb_checker (.*);
